// ----- rtl/circular_deque_unit_defines.svh -----
// Assertion macros shared by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define CDQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CDQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cdq_pkg.sv -----
// Types and constants for the circular deque unit.
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 4;

    // Operation requested by an input item
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    // Result status
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_mode                    mode;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    // Command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_REAR,
        CELL_POP_FRONT,
        CELL_POP_REAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [WORD_W-1:0] word;
    } t_cell_ctl;

endpackage

// ----- rtl/cdq_cell.sv -----
// One storage cell of the deque row: a word, its valid bit and neighbor shifting.
module cdq_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cdq_pkg::t_cell_ctl             i_ctl,
    input  logic [cdq_pkg::WORD_W-1:0]     i_left_data,
    input  logic                           i_left_valid,
    input  logic [cdq_pkg::WORD_W-1:0]     i_right_data,
    input  logic                           i_right_valid,
    output logic [cdq_pkg::WORD_W-1:0]     o_data,
    output logic                           o_valid,
    output logic                           o_is_rear
);

    logic [cdq_pkg::WORD_W-1:0] r_data;
    logic [cdq_pkg::WORD_W-1:0] n_data;
    logic                       r_valid;
    logic                       n_valid;

    // Front ops shift the whole row; rear ops touch only the boundary cell
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        case (i_ctl.op)
            cdq_pkg::CELL_PUSH_FRONT: begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end
            cdq_pkg::CELL_PUSH_REAR: begin
                if (!r_valid && i_left_valid) begin
                    n_data  = i_ctl.word;
                    n_valid = 1'b1;
                end
            end
            cdq_pkg::CELL_POP_FRONT: begin
                n_data  = i_right_data;
                n_valid = i_right_valid;
            end
            cdq_pkg::CELL_POP_REAR: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_valid   = r_valid;
    assign o_is_rear = r_valid && !i_right_valid;

endmodule

// ----- rtl/circular_deque_unit.sv -----
// Top level of the circular deque: row of storage cells, operation control, result register.
//
// Double-ended queue of DEPTH signed 32-bit words kept packed in a row of cells, front word
// in the first cell. Every push or pop at either end is a single row update: a front push or
// pop shifts all cells by one place in the same cycle, a rear push or pop changes only the
// cell at the occupied boundary. One item is accepted per cycle unless stalled, and its
// result appears in the output register on the following cycle. The input stalls only while
// a result sits in that register and the output side stalls it. Refused pushes (store full)
// and pops (store empty) leave the contents unchanged and still return one result.
`include "circular_deque_unit_defines.svh"

module circular_deque_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cdq_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cdq_pkg::t_out_item o_out_data
);

    localparam int DEPTH  = cdq_pkg::DEPTH;
    localparam int WORD_W = cdq_pkg::WORD_W;
    localparam int CNT_W  = cdq_pkg::CNT_W;
    localparam int OCC_W  = cdq_pkg::OCC_W;

    // Cell row wiring
    logic [WORD_W-1:0]  cell_data   [DEPTH];
    logic [WORD_W-1:0]  left_data   [DEPTH];
    logic [WORD_W-1:0]  right_data  [DEPTH];
    logic [DEPTH-1:0]   cell_valid;
    logic [DEPTH-1:0]   left_valid;
    logic [DEPTH-1:0]   right_valid;
    logic [DEPTH-1:0]   is_rear;
    cdq_pkg::t_cell_ctl cell_ctl;

    // Control and result
    logic               accept;
    logic               full;
    logic               empty;
    logic               push_ok;
    logic [WORD_W-1:0]  rear_word;
    logic [WORD_W-1:0]  popped;
    cdq_pkg::t_status   status;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    cdq_pkg::t_out_item r_out_data;
    cdq_pkg::t_out_item n_out_data;

    // Neighbor links; the new word enters at the front end
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_data[g]  = i_in_data.push_value;
            assign left_valid[g] = 1'b1;
        end else begin : g_inner_left
            assign left_data[g]  = cell_data[g-1];
            assign left_valid[g] = cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data[g]  = '0;
            assign right_valid[g] = 1'b0;
        end else begin : g_inner_right
            assign right_data[g]  = cell_data[g+1];
            assign right_valid[g] = cell_valid[g+1];
        end

        cdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_left_data   (left_data[g]),
            .i_left_valid  (left_valid[g]),
            .i_right_data  (right_data[g]),
            .i_right_valid (right_valid[g]),
            .o_data        (cell_data[g]),
            .o_valid       (cell_valid[g]),
            .o_is_rear     (is_rear[g])
        );
    end

    // Rear word: only the boundary cell flags itself, so an OR of masked words selects it
    always_comb begin
        rear_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rear_word = rear_word | (cell_data[k] & {WORD_W{is_rear[k]}});
        end
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = cell_valid[DEPTH-1];
    assign empty      = !cell_valid[0];
    assign push_ok    = accept && !full &&
                        (i_in_data.mode == cdq_pkg::MODE_PUSH_FRONT ||
                         i_in_data.mode == cdq_pkg::MODE_PUSH_REAR);

    // Operation decode: cell command, status, popped word, next fill count
    always_comb begin
        cell_ctl.word = i_in_data.push_value;
        cell_ctl.op   = cdq_pkg::CELL_HOLD;
        status        = cdq_pkg::ST_OK;
        popped        = '0;
        n_count       = r_count;
        case (i_in_data.mode)
            cdq_pkg::MODE_PUSH_FRONT: begin
                if (full) begin
                    status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    cell_ctl.op = cdq_pkg::CELL_PUSH_FRONT;
                    n_count     = r_count + 1'b1;
                end
            end
            cdq_pkg::MODE_PUSH_REAR: begin
                if (full) begin
                    status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    cell_ctl.op = cdq_pkg::CELL_PUSH_REAR;
                    n_count     = r_count + 1'b1;
                end
            end
            cdq_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                    status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    cell_ctl.op = cdq_pkg::CELL_POP_FRONT;
                    popped      = cell_data[0];
                    n_count     = r_count - 1'b1;
                end
            end
            cdq_pkg::MODE_POP_REAR: begin
                if (empty) begin
                    status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    cell_ctl.op = cdq_pkg::CELL_POP_REAR;
                    popped      = rear_word;
                    n_count     = r_count - 1'b1;
                end
            end
            default: ;
        endcase
        if (!accept) begin
            cell_ctl.op = cdq_pkg::CELL_HOLD;
            n_count     = r_count;
        end
    end

    // Result register: loaded on each input transfer, held while stalled
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (accept) begin
            n_out_valid             = 1'b1;
            n_out_data.popped_value = popped;
            n_out_data.status       = status;
            n_out_data.occupancy    = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks on the cell row and the fill count
    `CDQ_ASSERT_ALWAYS(a_count_matches_cells, r_count == $countones(cell_valid), "fill count disagrees with cell valid bits")
    `CDQ_ASSERT_ALWAYS(a_cells_packed, ((cell_valid + 1'b1) & cell_valid) == '0, "occupied cells not packed at front")
    `CDQ_ASSERT_IMPLY(a_one_rear, !empty, $onehot(is_rear), "nonempty row without exactly one rear cell")
    `CDQ_ASSERT_NEXT(a_push_grows, push_ok, r_count == $past(r_count) + 1'b1, "push did not grow the fill count")
    `CDQ_ASSERT_IMPLY(a_underflow_empty, r_out_valid && r_out_data.status == cdq_pkg::ST_UNDERFLOW, r_out_data.occupancy == '0, "underflow reported with nonzero occupancy")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the circular deque unit: directed, random and backpressure tests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int IDX_W       = $clog2(DEPTH);
    localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int DRAIN_WAIT  = 5;      // single result register, plus margin

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // DUT connections
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    circular_deque_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Deque shadow state
    logic signed [WORD_W-1:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]         shadow_head = '0;
    logic [IDX_W-1:0]         shadow_tail = '0;
    int                       shadow_fill = 0;

    t_out_item expected_results [$];
    int        error_count  = 0;
    bit        idle_enable  = 1'b1;
    int        hold_request = 0;     // receiver hold-off length asked by a test, cycles

    function automatic logic [IDX_W-1:0] idx_up(logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Apply one operation to the shadow deque and return the result it must produce
    function automatic t_out_item deque_apply(t_in_item it);
        t_out_item res;
        res = '0;
        res.status = ST_OK;
        if (it.mode == MODE_PUSH_FRONT || it.mode == MODE_PUSH_REAR) begin
            if (shadow_fill >= DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                if (shadow_fill == 0) begin
                    shadow_head     = '0;
                    shadow_tail     = '0;
                    shadow_store[0] = it.push_value;
                end else if (it.mode == MODE_PUSH_FRONT) begin
                    shadow_head               = idx_down(shadow_head);
                    shadow_store[shadow_head] = it.push_value;
                end else begin
                    shadow_tail               = idx_up(shadow_tail);
                    shadow_store[shadow_tail] = it.push_value;
                end
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.popped_value = (it.mode == MODE_POP_FRONT) ? shadow_store[shadow_head]
                                                               : shadow_store[shadow_tail];
                shadow_fill--;
                if (shadow_fill == 0) begin
                    shadow_head = '0;
                    shadow_tail = '0;
                end else if (it.mode == MODE_POP_FRONT) begin
                    shadow_head = idx_up(shadow_head);
                end else begin
                    shadow_tail = idx_down(shadow_tail);
                end
            end
        end
        res.occupancy = OCC_W'(shadow_fill);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Data word: corner values mixed into plain random words
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(WORD_W-1){1'b0}}};
            1: return {1'b0, {(WORD_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one operation and hold it until the transfer completes
    task automatic send_item(input t_mode m, input logic signed [WORD_W-1:0] v);
        t_in_item it;
        int       gap;
        it.mode       = m;
        it.push_value = v;
        gap           = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // Items go in strictly in order, so predict as soon as one is offered
        expected_results.push_back(deque_apply(it));
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge clk) begin
        int stall_left;
        int hold_left;
        bit hold_taken;
        int n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end else begin
            // A requested hold-off is taken over once and counted down here
            if (hold_request > 0 && !hold_taken) begin
                hold_left  = hold_request;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_stall  <= 1'b1;
                    stall_left = n - 1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Result checker
    always @(posedge clk) begin
        t_out_item exp_res;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", out_data);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (out_data.popped_value !== exp_res.popped_value) begin
                    $error("popped_value: expected %0d, actual %0d",
                           exp_res.popped_value, out_data.popped_value);
                    error_count++;
                end
                if (out_data.status !== exp_res.status) begin
                    $error("status: expected %s, actual %0d",
                           exp_res.status.name(), out_data.status);
                    error_count++;
                end
                if (out_data.occupancy !== exp_res.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           exp_res.occupancy, out_data.occupancy);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        int quiet;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("[circular_deque_unit] ERROR");
                $finish;
            end
        end
    end

    // Empty pops, fill to full from both ends, overflow, drain from both ends
    task automatic test_directed();
        send_item(MODE_POP_FRONT, 32'h1234_5678);
        send_item(MODE_POP_REAR,  '1);
        send_item(MODE_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}});  // push into empty
        send_item(MODE_PUSH_REAR,  {1'b0, {(WORD_W-1){1'b1}}});
        send_item(MODE_PUSH_FRONT, '1);
        send_item(MODE_PUSH_REAR,  '0);
        send_item(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        send_item(MODE_PUSH_REAR,  32'h5555_5555);
        send_item(MODE_PUSH_FRONT, 32'd1);
        send_item(MODE_PUSH_REAR,  32'hDEAD_BEEF);
        send_item(MODE_PUSH_FRONT, 32'h0BAD_F00D);               // full push front
        send_item(MODE_PUSH_REAR,  32'hCAFE_0001);               // full push rear
        for (int i = 0; i < DEPTH / 2; i++) begin
            send_item(MODE_POP_FRONT, '0);
            send_item(MODE_POP_REAR,  '1);
        end
        send_item(MODE_POP_REAR,   '0);                          // empty again
        send_item(MODE_PUSH_REAR,  32'h8000_0001);               // push rear into empty
        send_item(MODE_POP_FRONT,  '0);                          // pop of the last word
        send_item(MODE_PUSH_FRONT, 32'h7FFF_FFFE);
        send_item(MODE_POP_REAR,   '0);
    endtask

    // Random operations with a given share of pushes
    task automatic run_mix(input int count, input int push_pct);
        t_mode m;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < push_pct)
                m = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else
                m = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
            send_item(m, pick_word());
        end
    endtask

    task automatic test_random_balanced();
        run_mix(350, 50);
    endtask

    // Swing between nearly full and nearly empty so both limits are hit often
    task automatic test_fill_drain_swings();
        for (int i = 0; i < 12; i++) begin
            run_mix($urandom_range(10, 25), 85);
            run_mix($urandom_range(10, 25), 15);
        end
    endtask

    // Back-to-back traffic with no gaps on either side
    task automatic test_no_idle();
        idle_enable = 1'b0;
        run_mix(150, 55);
        idle_enable = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        idle_enable  = 1'b0;
        hold_request = 200;
        run_mix(40, 60);
        idle_enable  = 1'b1;
        run_mix(50, 50);
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_balanced();
        test_fill_drain_swings();
        test_no_idle();
        test_backpressure();
        run_mix(100, 50);

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0) begin
            $display("[circular_deque_unit] OK");
        end else begin
            $display("[circular_deque_unit] ERROR");
        end
        $finish;
    end

endmodule
